>>> hdl/utisd_pkg.sv
// utisd_pkg: shared sizes, operation codes and word types for the unsorted table.
// Depends on nothing; used by utisd_store and unsorted_table_insert_search_delete.
`default_nettype none
package utisd_pkg;

    localparam int DEPTH         = 64;
    localparam int KEY_WIDTH     = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int KIND_WIDTH    = 3;
    localparam int AW            = $clog2(DEPTH);
    localparam int CW            = $clog2(DEPTH + 1);

    // operation codes; 6 and 7 are unused and do nothing
    localparam logic [KIND_WIDTH-1:0] KIND_INSERT   = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_RETRIEVE = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_DEL_ONE  = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_DEL_ALL  = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_RESET    = 3'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_NEXT     = 3'd5;

    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    typedef struct packed {
        logic [KIND_WIDTH-1:0]    kind;
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } t_cmd;

    typedef struct packed {
        logic                     found;
        logic [KEY_WIDTH-1:0]     key_out;
        logic [PAYLOAD_WIDTH-1:0] payload_out;
        logic [CW-1:0]            count;
        logic                     full_res;
        logic                     error;
    } t_res;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        t_entry        ent;
    } t_wr_req;

endpackage
`default_nettype wire

>>> hdl/unsorted_table_insert_search_delete.sv
// Unsorted key/value table: insert, retrieve, delete first/all, cursor reset and read.
// Insert, cursor reset, unused kinds finish from idle (busy stays low); retrieve and
// deletes scan, a delete moving the last entry to the freed slot (delete all rescans from
// it). The scan reads one entry per cycle until a match, via the single memory read port.
// Throughput: one word at a time, the next taken once busy is low; o_done strobes 1 cycle.
// The receiver cannot stall. Synchronous active-low reset empties table, zeroes cursor.
`default_nettype none
module unsorted_table_insert_search_delete (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire utisd_pkg::t_cmd   i_cmd,
    output logic                   busy,
    output logic                   o_done,
    output utisd_pkg::t_res        o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,     // stream entries through the compare, one read per cycle until a match
        S_LAST_RD,  // fetch the last entry to fill a freed slot
        S_LAST_WR,  // write it back into the slot, shrink the count
        S_GET       // cursor read data arriving
    } t_state;

    t_state                              r_state, n_state;
    logic [utisd_pkg::CW-1:0]            r_count, n_count;
    logic [utisd_pkg::CW-1:0]            r_cursor, n_cursor;
    logic [utisd_pkg::CW-1:0]            r_idx, n_idx;      // next entry to read in a scan
    logic [utisd_pkg::AW-1:0]            r_cidx, n_cidx;    // entry whose data is on the read port
    logic                                r_pend, n_pend;    // read data valid for compare
    logic [utisd_pkg::AW-1:0]            r_slot, n_slot;    // slot being refilled
    logic                                r_found, n_found;
    logic [utisd_pkg::KIND_WIDTH-1:0]    r_kind, n_kind;
    logic [utisd_pkg::KEY_WIDTH-1:0]     r_key, n_key;
    logic                                r_done, n_done;
    utisd_pkg::t_res                     r_res, n_res;

    utisd_pkg::t_wr_req                  wr;
    logic                                rd_en;
    logic [utisd_pkg::AW-1:0]            rd_addr;
    utisd_pkg::t_entry                   rd_ent;
    logic [utisd_pkg::CW-1:0]            last;
    logic                                match;

    utisd_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_ent  (rd_ent)
    );

    assign last  = r_count - utisd_pkg::CW'(1);
    assign match = r_pend && (rd_ent.key == r_key);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_cidx   = r_cidx;
        n_pend   = r_pend;
        n_slot   = r_slot;
        n_found  = r_found;
        n_kind   = r_kind;
        n_key    = r_key;
        n_done   = 1'b0;
        n_res    = r_res;
        rd_en    = 1'b0;
        rd_addr  = r_idx[utisd_pkg::AW-1:0];
        wr.en    = 1'b0;
        wr.addr  = r_count[utisd_pkg::AW-1:0];
        wr.ent   = rd_ent;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind            = i_cmd.kind;
                    n_key             = i_cmd.key;
                    n_res.found       = 1'b0;
                    n_res.key_out     = i_cmd.key;
                    n_res.payload_out = '0;
                    n_res.error       = 1'b0;
                    case (i_cmd.kind)
                        utisd_pkg::KIND_INSERT: begin
                            n_done = 1'b1;
                            if (r_count >= utisd_pkg::COUNT_FULL) begin
                                n_res.error = 1'b1;
                            end else begin
                                wr.en       = 1'b1;
                                wr.ent.key     = i_cmd.key;
                                wr.ent.payload = i_cmd.payload;
                                n_count     = r_count + utisd_pkg::CW'(1);
                            end
                        end
                        utisd_pkg::KIND_RETRIEVE,
                        utisd_pkg::KIND_DEL_ONE,
                        utisd_pkg::KIND_DEL_ALL: begin
                            n_state = S_SCAN;
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_found = 1'b0;
                        end
                        utisd_pkg::KIND_RESET: begin
                            n_cursor = '0;
                            n_done   = 1'b1;
                        end
                        utisd_pkg::KIND_NEXT: begin
                            if (r_cursor < r_count) begin
                                rd_en   = 1'b1;
                                rd_addr = r_cursor[utisd_pkg::AW-1:0];
                                n_state = S_GET;
                            end else begin
                                n_res.error = 1'b1;
                                n_done      = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_GET: begin
                n_res.key_out     = rd_ent.key;
                n_res.payload_out = rd_ent.payload;
                n_cursor          = r_cursor + utisd_pkg::CW'(1);
                n_done            = 1'b1;
                n_state           = S_IDLE;
            end
            S_SCAN: begin
                if (match) begin
                    n_pend = 1'b0;
                    if (r_kind == utisd_pkg::KIND_RETRIEVE) begin
                        n_res.found       = 1'b1;
                        n_res.key_out     = rd_ent.key;
                        n_res.payload_out = rd_ent.payload;
                        n_done            = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        n_found = 1'b1;
                        n_slot  = r_cidx;
                        n_state = S_LAST_RD;
                    end
                end else if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    n_pend  = 1'b1;
                    n_cidx  = r_idx[utisd_pkg::AW-1:0];
                    n_idx   = r_idx + utisd_pkg::CW'(1);
                end else begin
                    // scan ran off the end
                    n_pend      = 1'b0;
                    n_res.found = r_found;
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_LAST_RD: begin
                rd_en   = 1'b1;
                rd_addr = last[utisd_pkg::AW-1:0];
                n_state = S_LAST_WR;
            end
            S_LAST_WR: begin
                wr.en   = 1'b1;
                wr.addr = r_slot;
                wr.ent  = rd_ent;
                n_count = last;
                if (r_kind == utisd_pkg::KIND_DEL_ALL) begin
                    // recheck the refilled slot
                    n_idx   = utisd_pkg::CW'(r_slot);
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_res.found = 1'b1;
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.count    = n_count;
        n_res.full_res = (n_count == utisd_pkg::COUNT_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_pend   <= n_pend;
            r_found  <= n_found;
            r_done   <= n_done;
        end
        r_idx  <= n_idx;
        r_cidx <= n_cidx;
        r_slot <= n_slot;
        r_kind <= n_kind;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= utisd_pkg::COUNT_FULL)
        else $error("entry count above capacity");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.count == r_count))
        else $error("reported count differs from table count");

    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("operation ended without a result word");

    a_found_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.found) |-> !o_res.error)
        else $error("found and error both set");

    a_write_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST_WR) |=> (r_count == $past(r_count) - utisd_pkg::CW'(1)))
        else $error("refill did not shrink the table");
`endif

endmodule
`default_nettype wire

>>> hdl/utisd_store.sv
// utisd_store: entry memory of the table, one write and one registered read per cycle.
// Depends on utisd_pkg for entry and write request types.
`default_nettype none
module utisd_store (
    input  wire logic                  i_clk,
    input  wire utisd_pkg::t_wr_req    i_wr,
    input  wire logic                  i_rd_en,
    input  wire logic [utisd_pkg::AW-1:0] i_rd_addr,
    output utisd_pkg::t_entry          o_rd_ent
);

    utisd_pkg::t_entry r_mem [utisd_pkg::DEPTH];
    utisd_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.ent;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_ent = r_rd;

endmodule
`default_nettype wire
